// ===== rtl/glcd_pkg.sv =====
`timescale 1ns / 1ps

package glcd_pkg;

    // Port write kinds
    localparam logic [1:0] FUNC_PIXEL  = 2'd0;
    localparam logic [1:0] FUNC_COLUMN = 2'd1;
    localparam logic [1:0] FUNC_ROW    = 2'd2;
    localparam logic [1:0] FUNC_MODE   = 2'd3;

    // Mode byte fields
    localparam int         HOME_BIT       = 7;
    localparam logic [4:0] MODE_SCROLL_UP = 5'd5;
    localparam logic [4:0] MODE_SCROLL_DN = 5'd6;
    localparam logic [4:0] MODE_INVERT    = 5'd8;
    localparam logic [4:0] MODE_CLEAR     = 5'd16;

    localparam int CELL_COL_W = 3;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        SW_UP   = 2'd0,
        SW_DOWN = 2'd1,
        SW_INV  = 2'd2,
        SW_CLR  = 2'd3
    } sweep_op_t;

    // Low four codes match the combine mode register
    typedef enum logic [2:0] {
        ALU_SET  = 3'd0,
        ALU_XOR  = 3'd1,
        ALU_OR   = 3'd2,
        ALU_AND  = 3'd3,
        ALU_PASS = 3'd4
    } alu_op_t;

    typedef struct packed {
        logic       en;
        alu_op_t    op;
        logic [7:0] operand;
    } wr_req_t;

    function automatic logic [7:0] glcd_combine(alu_op_t op, logic [7:0] old_byte,
                                                logic [7:0] operand);
        logic [7:0] res;
        unique case (op)
            ALU_SET:  res = operand;
            ALU_XOR:  res = old_byte ^ operand;
            ALU_OR:   res = old_byte | operand;
            ALU_AND:  res = old_byte & operand;
            ALU_PASS: res = old_byte;
            default:  res = old_byte;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/glcd_store.sv =====
`timescale 1ns / 1ps

module glcd_store #(
    parameter int DEPTH = 480,
    parameter int AW    = 9
) (
    input  logic              aclk,
    input  logic [AW-1:0]     rd_addr,
    input  glcd_pkg::wr_req_t wr_req,
    input  logic [AW-1:0]     wr_addr,
    output logic [7:0]        wr_data
);
    import glcd_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Combine the registered read word with the operand
    assign wr_data = glcd_combine(wr_req.op, rd_data_reg, wr_req.operand);

    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ===== rtl/graphic_lcd_controller.sv =====
`timescale 1ns / 1ps

// Graphic LCD controller with a frame store of TEXT_COLUMNS*CELL_WIDTH*TEXT_ROWS
// byte columns held in one single-port-write, registered-read memory. Every
// input word yields exactly one result word. Pixel, cursor and plain mode words
// are accepted, then finish once the output register is free; a pixel word does
// one read-modify-write pass through the combine unit. Scroll, invert and clear
// walk the store one byte per cycle through the same unit and then report once
// the output register is free. After reset the block clears the store in a
// pass with s_ready low. s_ready is high whenever the sequencer is idle, even
// while a result waits on the output register.
module graphic_lcd_controller #(
    parameter int TEXT_COLUMNS = 20,
    parameter int TEXT_ROWS    = 4,
    parameter int CELL_WIDTH   = 6
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [7:0] s_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_written,
    output logic [6:0] m_column,
    output logic [1:0] m_row,
    output logic [7:0] m_pixel_byte,
    output logic       m_out_of_range,
    output logic       m_full_redraw
);
    import glcd_pkg::*;

    localparam int PIX_COLS = TEXT_COLUMNS * CELL_WIDTH;
    localparam int DEPTH    = PIX_COLS * TEXT_ROWS;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW       = (PIX_COLS > 1) ? $clog2(PIX_COLS) : 1;
    localparam int RW       = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(TEXT_ROWS - 1);

    state_t                state_reg, state_next;
    logic [1:0]            func_reg, func_next;
    logic [7:0]            value_reg, value_next;
    logic [7:0]            cursor_cell_reg, cursor_cell_next;
    logic [7:0]            cursor_row_reg, cursor_row_next;
    logic [CELL_COL_W-1:0] cell_col_reg, cell_col_next;
    logic [1:0]            mode_reg, mode_next;
    sweep_op_t             sw_op_reg, sw_op_next;
    logic [AW-1:0]         dst_reg, dst_next;
    logic [RW-1:0]         srow_reg, srow_next;
    logic                  emit_reg, emit_next;
    logic                  p_valid_reg, p_valid_next;
    logic [AW-1:0]         p_addr_reg, p_addr_next;
    alu_op_t               p_op_reg, p_op_next;
    logic [7:0]            p_operand_reg, p_operand_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  written_reg, written_next;
    logic [6:0]            column_reg, column_next;
    logic [1:0]            row_reg, row_next;
    logic [7:0]            pbyte_reg, pbyte_next;
    logic                  oor_reg, oor_next;
    logic                  redraw_reg, redraw_next;

    logic                  slot_free;
    logic                  in_range;
    logic [CW-1:0]         pix_col;
    logic [AW-1:0]         cur_addr;
    logic [CELL_COL_W:0]   cell_inc;
    logic [4:0]            mode_sel;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [7:0]            wr_data;
    wr_req_t               wr_req;
    logic                  pix_commit;
    logic                  sw_zero;
    logic                  sw_last;
    logic [AW-1:0]         sw_src;

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_written      = written_reg;
    assign m_column       = column_reg;
    assign m_row          = row_reg;
    assign m_pixel_byte   = pbyte_reg;
    assign m_out_of_range = oor_reg;
    assign m_full_redraw  = redraw_reg;

    assign slot_free = !m_valid_reg || m_ready;
    assign in_range  = (32'(cursor_cell_reg) < 32'(TEXT_COLUMNS)) &&
                       (32'(cursor_row_reg) < 32'(TEXT_ROWS));
    assign pix_col   = CW'(32'(cursor_cell_reg) * CELL_WIDTH + 32'(cell_col_reg));
    assign cur_addr  = AW'(32'(pix_col) * TEXT_ROWS + 32'(cursor_row_reg));
    assign cell_inc  = {1'b0, cell_col_reg} + 1'b1;
    assign mode_sel  = value_reg[6:2];

    // Sweep address generation
    always_comb begin
        sw_zero = 1'b0;
        sw_src  = dst_reg;
        sw_last = (dst_reg == LAST_ADDR);
        case (sw_op_reg)
            SW_UP: begin
                sw_zero = (srow_reg == LAST_ROW);
                sw_src  = dst_reg + 1'b1;
            end
            SW_DOWN: begin
                sw_zero = (srow_reg == '0);
                sw_src  = dst_reg - 1'b1;
                sw_last = (dst_reg == '0);
            end
            default: begin
                sw_src = dst_reg;
            end
        endcase
    end

    assign rd_addr = (state_reg == ST_SWEEP) ? sw_src : cur_addr;

    always_comb begin
        pix_commit = (state_reg == ST_EXEC) && slot_free && (func_reg == FUNC_PIXEL)
                     && in_range;
        if (p_valid_reg) begin
            wr_req  = '{en: 1'b1, op: p_op_reg, operand: p_operand_reg};
            wr_addr = p_addr_reg;
        end else begin
            wr_req  = '{en: pix_commit, op: alu_op_t'({1'b0, mode_reg}),
                        operand: value_reg};
            wr_addr = cur_addr;
        end
    end

    glcd_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .rd_addr (rd_addr),
        .wr_req  (wr_req),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_comb begin
        state_next       = state_reg;
        func_next        = func_reg;
        value_next       = value_reg;
        cursor_cell_next = cursor_cell_reg;
        cursor_row_next  = cursor_row_reg;
        cell_col_next    = cell_col_reg;
        mode_next        = mode_reg;
        sw_op_next       = sw_op_reg;
        dst_next         = dst_reg;
        srow_next        = srow_reg;
        emit_next        = emit_reg;
        p_valid_next     = 1'b0;
        p_addr_next      = p_addr_reg;
        p_op_next        = p_op_reg;
        p_operand_next   = p_operand_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        written_next     = written_reg;
        column_next      = column_reg;
        row_next         = row_reg;
        pbyte_next       = pbyte_reg;
        oor_next         = oor_reg;
        redraw_next      = redraw_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next  = s_func;
                    value_next = s_value;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    written_next = 1'b0;
                    column_next  = '0;
                    row_next     = '0;
                    pbyte_next   = '0;
                    oor_next     = 1'b0;
                    redraw_next  = 1'b0;
                    state_next   = ST_IDLE;
                    unique case (func_reg)
                        FUNC_PIXEL: begin
                            if (in_range) begin
                                written_next = 1'b1;
                                column_next  = 7'(pix_col);
                                row_next     = cursor_row_reg[1:0];
                                pbyte_next   = wr_data;
                                if (32'(cell_inc) >= 32'(CELL_WIDTH)) begin
                                    cell_col_next    = '0;
                                    cursor_cell_next = cursor_cell_reg + 1'b1;
                                end else begin
                                    cell_col_next = cell_inc[CELL_COL_W-1:0];
                                end
                            end else begin
                                oor_next = 1'b1;
                            end
                        end
                        FUNC_COLUMN: begin
                            cursor_cell_next = value_reg;
                        end
                        FUNC_ROW: begin
                            cursor_row_next = value_reg;
                        end
                        FUNC_MODE: begin
                            if (value_reg[HOME_BIT]) begin
                                cursor_cell_next = '0;
                                cursor_row_next  = '0;
                            end
                            if (value_reg[6:5] != 2'b00) begin
                                mode_next = value_reg[1:0];
                            end
                            // Bulk operations report once the sweep is done
                            case (mode_sel) inside
                                MODE_SCROLL_UP, MODE_SCROLL_DN, MODE_INVERT,
                                MODE_CLEAR: begin
                                    m_valid_next = m_valid_reg && !m_ready;
                                    emit_next    = 1'b1;
                                    state_next   = ST_SWEEP;
                                    dst_next     = '0;
                                    srow_next    = '0;
                                    if (mode_sel == MODE_SCROLL_UP) begin
                                        sw_op_next = SW_UP;
                                    end else if (mode_sel == MODE_SCROLL_DN) begin
                                        sw_op_next = SW_DOWN;
                                        dst_next   = LAST_ADDR;
                                        srow_next  = LAST_ROW;
                                    end else if (mode_sel == MODE_INVERT) begin
                                        sw_op_next = SW_INV;
                                    end else begin
                                        sw_op_next = SW_CLR;
                                    end
                                end
                                default: begin
                                    emit_next = 1'b0;
                                end
                            endcase
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                // Issue one read; the write lands on the next cycle
                p_valid_next = 1'b1;
                p_addr_next  = dst_reg;
                case (sw_op_reg)
                    SW_INV: begin
                        p_op_next      = ALU_XOR;
                        p_operand_next = 8'hff;
                    end
                    SW_CLR: begin
                        p_op_next      = ALU_SET;
                        p_operand_next = 8'h00;
                    end
                    default: begin
                        p_op_next      = sw_zero ? ALU_SET : ALU_PASS;
                        p_operand_next = 8'h00;
                    end
                endcase
                if (sw_op_reg == SW_DOWN) begin
                    dst_next  = dst_reg - 1'b1;
                    srow_next = (srow_reg == '0) ? LAST_ROW : srow_reg - 1'b1;
                end else begin
                    dst_next  = dst_reg + 1'b1;
                    srow_next = (srow_reg == LAST_ROW) ? '0 : srow_reg + 1'b1;
                end
                if (sw_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!emit_reg) begin
                    state_next = ST_IDLE;
                end else if (slot_free) begin
                    m_valid_next = 1'b1;
                    written_next = 1'b0;
                    column_next  = '0;
                    row_next     = '0;
                    pbyte_next   = '0;
                    oor_next     = 1'b0;
                    redraw_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // Start with a clearing pass over the store
            state_reg       <= ST_SWEEP;
            sw_op_reg       <= SW_CLR;
            dst_reg         <= '0;
            srow_reg        <= '0;
            emit_reg        <= 1'b0;
            p_valid_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            cursor_cell_reg <= '0;
            cursor_row_reg  <= '0;
            cell_col_reg    <= '0;
            mode_reg        <= '0;
        end else begin
            state_reg       <= state_next;
            sw_op_reg       <= sw_op_next;
            dst_reg         <= dst_next;
            srow_reg        <= srow_next;
            emit_reg        <= emit_next;
            p_valid_reg     <= p_valid_next;
            m_valid_reg     <= m_valid_next;
            cursor_cell_reg <= cursor_cell_next;
            cursor_row_reg  <= cursor_row_next;
            cell_col_reg    <= cell_col_next;
            mode_reg        <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        value_reg     <= value_next;
        p_addr_reg    <= p_addr_next;
        p_op_reg      <= p_op_next;
        p_operand_reg <= p_operand_next;
        written_reg   <= written_next;
        column_reg    <= column_next;
        row_reg       <= row_next;
        pbyte_reg     <= pbyte_next;
        oor_reg       <= oor_next;
        redraw_reg    <= redraw_next;
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import glcd_pkg::*;

    localparam int TEXT_COLUMNS   = 20;
    localparam int TEXT_ROWS      = 4;
    localparam int CELL_WIDTH     = 6;
    localparam int PIX_COLS       = TEXT_COLUMNS * CELL_WIDTH;
    localparam int STORE_BYTES    = PIX_COLS * TEXT_ROWS;
    localparam int TOTAL_WORDS    = 950;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = STORE_BYTES + 40;
    localparam int LONG_HOLD      = 80;

    typedef struct packed {
        logic       written;
        logic [6:0] column;
        logic [1:0] row;
        logic [7:0] pbyte;
        logic       oor;
        logic       redraw;
    } lcd_result_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  value;
        logic        typed;
        lcd_result_t want;
    } lcd_row_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic [1:0] s_func  = FUNC_PIXEL;
    logic [7:0] s_value = 8'h00;
    logic       m_ready = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic       m_written;
    logic [6:0] m_column;
    logic [1:0] m_row;
    logic [7:0] m_pixel_byte;
    logic       m_out_of_range;
    logic       m_full_redraw;

    graphic_lcd_controller #(
        .TEXT_COLUMNS(TEXT_COLUMNS),
        .TEXT_ROWS   (TEXT_ROWS),
        .CELL_WIDTH  (CELL_WIDTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_written     (m_written),
        .m_column      (m_column),
        .m_row         (m_row),
        .m_pixel_byte  (m_pixel_byte),
        .m_out_of_range(m_out_of_range),
        .m_full_redraw (m_full_redraw)
    );

    always #1 aclk = ~aclk;

    // shadow of the display state
    logic [7:0] pix [PIX_COLS][TEXT_ROWS];
    logic [7:0] cur_cell;
    logic [7:0] cur_row;
    logic [2:0] cell_col;
    logic [1:0] combine_sel;

    lcd_result_t pending_q [$];
    int n_sent     = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_pixels   = 0;
    int n_rejected = 0;
    int n_bulk     = 0;

    function automatic lcd_result_t pack_result(logic w, int c, int r, logic [7:0] b,
                                                logic o, logic d);
        lcd_result_t res;
        res = '{w, c[6:0], r[1:0], b, o, d};
        return res;
    endfunction

    function automatic bit is_bulk(logic [7:0] v);
        return v[6:2] == MODE_SCROLL_UP || v[6:2] == MODE_SCROLL_DN ||
               v[6:2] == MODE_INVERT || v[6:2] == MODE_CLEAR;
    endfunction

    function automatic lcd_result_t lcd_apply(logic [1:0] f, logic [7:0] v);
        lcd_result_t res;
        int pcol;
        int c;
        int r;
        res = '0;
        case (f)
            FUNC_PIXEL: begin
                if (cur_cell >= TEXT_COLUMNS || cur_row >= TEXT_ROWS) begin
                    res.oor = 1'b1;
                    n_rejected++;
                end else begin
                    pcol = cur_cell * CELL_WIDTH + cell_col;
                    case (alu_op_t'({1'b0, combine_sel}))
                        ALU_SET: pix[pcol][cur_row] = v;
                        ALU_XOR: pix[pcol][cur_row] = pix[pcol][cur_row] ^ v;
                        ALU_OR:  pix[pcol][cur_row] = pix[pcol][cur_row] | v;
                        default: pix[pcol][cur_row] = pix[pcol][cur_row] & v;
                    endcase
                    res.written = 1'b1;
                    res.column  = pcol[6:0];
                    res.row     = cur_row[1:0];
                    res.pbyte   = pix[pcol][cur_row];
                    n_pixels++;
                    // wrap into the next character cell after its last column
                    if (cell_col == CELL_WIDTH - 1) begin
                        cell_col = '0;
                        cur_cell = cur_cell + 8'd1;
                    end else begin
                        cell_col = cell_col + 3'd1;
                    end
                end
            end
            FUNC_COLUMN: cur_cell = v;
            FUNC_ROW:    cur_row = v;
            default: begin
                if (v[HOME_BIT]) begin
                    cur_cell = '0;
                    cur_row  = '0;
                end
                case (v[6:2])
                    MODE_SCROLL_UP: begin
                        for (r = 0; r < TEXT_ROWS; r++)
                            for (c = 0; c < PIX_COLS; c++)
                                pix[c][r] = (r == TEXT_ROWS - 1) ? 8'h00 : pix[c][r + 1];
                    end
                    MODE_SCROLL_DN: begin
                        for (r = TEXT_ROWS - 1; r >= 0; r--)
                            for (c = 0; c < PIX_COLS; c++)
                                pix[c][r] = (r == 0) ? 8'h00 : pix[c][r - 1];
                    end
                    MODE_INVERT: begin
                        for (r = 0; r < TEXT_ROWS; r++)
                            for (c = 0; c < PIX_COLS; c++)
                                pix[c][r] = ~pix[c][r];
                    end
                    MODE_CLEAR: begin
                        for (r = 0; r < TEXT_ROWS; r++)
                            for (c = 0; c < PIX_COLS; c++)
                                pix[c][r] = 8'h00;
                    end
                    default: ;
                endcase
                if (is_bulk(v)) begin
                    res.redraw = 1'b1;
                    n_bulk++;
                end
                if (v[6:5] != 2'b00)
                    combine_sel = v[1:0];
            end
        endcase
        return res;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        n_errors++;
    endtask

    // hold valid and payload until taken, then queue what the word should produce
    task automatic push_word(logic [1:0] f, logic [7:0] v, logic typed, lcd_result_t want);
        int gap;
        lcd_result_t res;
        gap = (((n_sent / 100) % 4) == 3) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= f;
        s_value <= v;
        do @(posedge aclk); while (s_ready !== 1'b1);
        res = lcd_apply(f, v);
        pending_q.push_back(typed ? want : res);
        n_sent++;
    endtask

    task automatic push_random(logic [1:0] f, logic [7:0] v);
        push_word(f, v, 1'b0, '0);
    endtask

    task automatic check_result(lcd_result_t got);
        lcd_result_t want;
        if (pending_q.size() == 0) begin
            flag_mismatch($sformatf("result word %0h with nothing pending", got));
        end else begin
            want = pending_q.pop_front();
            if (got.written !== want.written)
                flag_mismatch($sformatf("written %b want %b", got.written, want.written));
            if (got.column !== want.column)
                flag_mismatch($sformatf("column %0d want %0d", got.column, want.column));
            if (got.row !== want.row)
                flag_mismatch($sformatf("row %0d want %0d", got.row, want.row));
            if (got.pbyte !== want.pbyte)
                flag_mismatch($sformatf("pixel_byte %h want %h", got.pbyte, want.pbyte));
            if (got.oor !== want.oor)
                flag_mismatch($sformatf("out_of_range %b want %b", got.oor, want.oor));
            if (got.redraw !== want.redraw)
                flag_mismatch($sformatf("full_redraw %b want %b", got.redraw, want.redraw));
        end
        n_checked++;
    endtask

    // result side: random stalls, two long holds to back up the block
    initial begin
        int k;
        forever begin
            k = (((n_checked / 90) % 4) == 2) ? 0 : $urandom_range(0, 3);
            if (n_checked == 150 || n_checked == 620)
                k = LONG_HOLD;
            if (k > 0) begin
                m_ready <= 1'b0;
                repeat (k) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            check_result('{m_written, m_column, m_row, m_pixel_byte,
                           m_out_of_range, m_full_redraw});
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready))
                idle = 0;
            else
                idle++;
            if (idle >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("FAIL graphic_lcd_controller");
                $finish;
            end
        end
    end

    lcd_row_t dir_tab [0:24];

    initial begin
        int i;
        int n;
        int sel;
        logic [1:0] f;
        logic [7:0] v;

        for (int c = 0; c < PIX_COLS; c++)
            for (int r = 0; r < TEXT_ROWS; r++)
                pix[c][r] = 8'h00;
        cur_cell    = '0;
        cur_row     = '0;
        cell_col    = '0;
        combine_sel = '0;

        dir_tab = '{
            '{FUNC_PIXEL,  8'hFF, 1'b1, pack_result(1, 0, 0, 8'hFF, 0, 0)},
            '{FUNC_PIXEL,  8'h00, 1'b1, pack_result(1, 1, 0, 8'h00, 0, 0)},
            '{FUNC_COLUMN, 8'd19, 1'b1, '0},
            '{FUNC_ROW,    8'd3,  1'b1, '0},
            '{FUNC_PIXEL,  8'h81, 1'b1, pack_result(1, 116, 3, 8'h81, 0, 0)},
            '{FUNC_PIXEL,  8'h7E, 1'b0, '0},
            '{FUNC_PIXEL,  8'h55, 1'b0, '0},
            '{FUNC_PIXEL,  8'hAA, 1'b0, '0},
            // cursor has wrapped past the last cell
            '{FUNC_PIXEL,  8'h01, 1'b0, '0},
            '{FUNC_PIXEL,  8'h80, 1'b1, pack_result(0, 0, 0, 8'h00, 1, 0)},
            '{FUNC_PIXEL,  8'h3C, 1'b1, pack_result(0, 0, 0, 8'h00, 1, 0)},
            '{FUNC_COLUMN, 8'hFF, 1'b1, '0},
            '{FUNC_ROW,    8'hFF, 1'b1, '0},
            '{FUNC_PIXEL,  8'hC3, 1'b1, pack_result(0, 0, 0, 8'h00, 1, 0)},
            '{FUNC_MODE,   8'h80, 1'b1, '0},
            '{FUNC_MODE,   8'h61, 1'b1, '0},
            '{FUNC_PIXEL,  8'h0F, 1'b0, '0},
            '{FUNC_MODE,   8'h14, 1'b1, pack_result(0, 0, 0, 8'h00, 0, 1)},
            '{FUNC_MODE,   8'h18, 1'b1, pack_result(0, 0, 0, 8'h00, 0, 1)},
            // invert and select OR in one word
            '{FUNC_MODE,   8'h22, 1'b1, pack_result(0, 0, 0, 8'h00, 0, 1)},
            '{FUNC_PIXEL,  8'h10, 1'b0, '0},
            // home, clear and select AND in one word
            '{FUNC_MODE,   8'hC3, 1'b1, pack_result(0, 0, 0, 8'h00, 0, 1)},
            '{FUNC_PIXEL,  8'hF0, 1'b0, '0},
            '{FUNC_MODE,   8'h7F, 1'b1, '0},
            '{FUNC_MODE,   8'h00, 1'b1, '0}
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < 25; i++)
            push_word(dir_tab[i].func, dir_tab[i].value, dir_tab[i].typed, dir_tab[i].want);

        while (n_sent < TOTAL_WORDS) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                // place the cursor on screen, then draw a run of bytes
                push_random(FUNC_COLUMN, 8'($urandom_range(0, TEXT_COLUMNS - 1)));
                push_random(FUNC_ROW, 8'($urandom_range(0, TEXT_ROWS - 1)));
                n = $urandom_range(1, 12);
                repeat (n) push_random(FUNC_PIXEL, 8'($urandom));
            end else if (sel < 70) begin
                v = 8'($urandom);
                v[6:5] = 2'($urandom_range(1, 3));
                if (is_bulk(v))
                    v = v ^ 8'h10;
                push_random(FUNC_MODE, v);
            end else if (sel < 73) begin
                v = 8'($urandom);
                case ($urandom_range(0, 3))
                    0: v[6:2] = MODE_SCROLL_UP;
                    1: v[6:2] = MODE_SCROLL_DN;
                    2: v[6:2] = MODE_INVERT;
                    default: v[6:2] = MODE_CLEAR;
                endcase
                push_random(FUNC_MODE, v);
            end else if (sel < 85) begin
                push_random(FUNC_PIXEL, 8'($urandom));
            end else begin
                f = 2'($urandom);
                v = 8'($urandom);
                // keep most noise away from the slow whole-store sweeps
                if (f == FUNC_MODE && is_bulk(v) && $urandom_range(0, 7) != 0)
                    v = v ^ 8'h10;
                push_random(f, v);
            end
        end
        s_valid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d words: %0d pixel writes, %0d rejected off-screen, %0d sweeps",
                 n_sent, n_pixels, n_rejected, n_bulk);
        $display("checked %0d result words, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0 && pending_q.size() == 0) begin
            $display("PASS graphic_lcd_controller");
        end else begin
            $display("FAIL graphic_lcd_controller");
        end
        $finish;
    end

endmodule
